// File: rtl/core/record_insertion_sorter_macros.svh
// assertion macros used by record_insertion_sorter.sv
`ifndef RECORD_INSERTION_SORTER_MACROS_SVH
`define RECORD_INSERTION_SORTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ris_pkg.sv
package ris_pkg;

  localparam int RECORDS     = 8;
  localparam int TEXT_BYTES  = 20;
  localparam int FIELD_BYTES = 20;
  localparam int TEXT_W      = 8 * FIELD_BYTES;
  localparam int TAG_W       = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W       = $clog2(RECORDS + 1);
  localparam int CMP_W       = TEXT_W + TAG_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } ris_state_t;

  typedef struct packed {
    logic [TEXT_W-1:0] name;
    logic [TEXT_W-1:0] region;
    logic [7:0]        age;
  } rec_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    rec_t             rec;
  } slot_t;

  typedef struct packed {
    logic  valid;
    slot_t slot;
  } cell_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
  } cell_ctl_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic sort_en;
    logic parity;
  } seq_ctl_t;

  // keeps only the bytes below TEXT_BYTES
  function automatic logic [TEXT_W-1:0] text_mask();
    logic [TEXT_W-1:0] m;
    m = '0;
    for (int b = 0; b < FIELD_BYTES; b++) begin
      if (b < TEXT_BYTES) begin
        m[TEXT_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  localparam logic [TEXT_W-1:0] TEXT_MASK = text_mask();

  // clears every byte from the first zero on, so a plain compare acts like strcmp
  function automatic logic [TEXT_W-1:0] name_key(input logic [TEXT_W-1:0] t);
    logic [TEXT_W-1:0] k;
    logic              seen;
    k    = t;
    seen = 1'b0;
    for (int b = 0; b < FIELD_BYTES; b++) begin
      if (seen) begin
        k[TEXT_W-1-8*b -: 8] = 8'h00;
      end else if (t[TEXT_W-1-8*b -: 8] == 8'h00) begin
        seen = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

// File: rtl/core/ris_if.sv
interface ris_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_a;
  logic [63:0] name_b;
  logic [31:0] name_c;
  logic [63:0] region_a;
  logic [63:0] region_b;
  logic [31:0] region_c;
  logic [7:0]  age;
  logic        final_record;

  modport source (
    output valid, name_a, name_b, name_c, region_a, region_b, region_c, age, final_record,
    input  ready
  );
  modport sink (
    input  valid, name_a, name_b, name_c, region_a, region_b, region_c, age, final_record,
    output ready
  );
endinterface

interface ris_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_name_a;
  logic [63:0] out_name_b;
  logic [31:0] out_name_c;
  logic [63:0] out_region_a;
  logic [63:0] out_region_b;
  logic [31:0] out_region_c;
  logic [7:0]  out_age;
  logic        dropped;
  logic        end_of_run;

  modport source (
    output valid, out_name_a, out_name_b, out_name_c, out_region_a, out_region_b,
           out_region_c, out_age, dropped, end_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_name_a, out_name_b, out_name_c, out_region_a, out_region_b,
           out_region_c, out_age, dropped, end_of_run,
    output ready
  );
endinterface

interface ris_cfg_if;
  logic valid;
  logic ready;
  logic sort_by_name;

  modport source (output valid, sort_by_name, input ready);
  modport sink (input valid, sort_by_name, output ready);
endinterface

// File: rtl/core/ris_cell.sv
module ris_cell import ris_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      by_name,
  input  cell_t     left_i,
  input  cell_t     right_i,
  output cell_t     cell_o,
  output logic      right_wins
);

  logic              valid_r, valid_nxt;
  slot_t             slot_r, slot_nxt;
  logic [TEXT_W-1:0] own_key, right_key;
  logic [CMP_W-1:0]  own_w, right_w;

  always_comb begin
    priority if (ctl.take_left) begin
      valid_nxt = left_i.valid;
      slot_nxt  = left_i.slot;
    end else if (ctl.take_right) begin
      valid_nxt = right_i.valid;
      slot_nxt  = right_i.slot;
    end else begin
      valid_nxt = valid_r;
      slot_nxt  = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign cell_o.valid = valid_r;
  assign cell_o.slot  = slot_r;

  // key, then older arrival wins a tie
  assign own_key   = by_name ? name_key(slot_r.rec.name) : TEXT_W'(slot_r.rec.age);
  assign right_key = by_name ? name_key(right_i.slot.rec.name) : TEXT_W'(right_i.slot.rec.age);
  assign own_w     = {own_key, ~slot_r.tag};
  assign right_w   = {right_key, ~right_i.slot.tag};

  assign right_wins = valid_r && right_i.valid && (right_w > own_w);

endmodule

// File: rtl/core/ris_ctrl.sv
module ris_ctrl import ris_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_acc,
  input  logic             in_final,
  input  logic             out_acc,
  input  logic             last_out,
  output seq_ctl_t         ctl,
  output logic             in_ready,
  output logic             out_valid,
  output logic             dropped,
  output logic [TAG_W-1:0] tag
);

  ris_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] round_r, round_nxt;
  logic             overflow_r, overflow_nxt;
  logic             has_room;
  logic             sort_done;
  logic             sort_en;

  assign has_room  = fill_r < CNT_W'(RECORDS);
  assign sort_done = round_r == CNT_W'(RECORDS - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_acc && in_final) state_nxt = ST_SORT;
      ST_SORT: if (sort_done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && last_out) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    sort_en   = 1'b0;
    unique case (state_r)
      ST_LOAD: in_ready  = 1'b1;
      ST_SORT: sort_en   = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

  assign ctl.sort_en    = sort_en;
  assign ctl.shift_up   = in_acc && has_room;
  assign ctl.shift_down = out_acc;
  assign ctl.parity     = round_r[0];
  assign dropped        = overflow_r;
  assign tag            = fill_r[TAG_W-1:0];

  always_comb begin
    fill_nxt     = fill_r;
    overflow_nxt = overflow_r;
    round_nxt    = round_r;
    if (in_acc) begin
      if (has_room) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        overflow_nxt = 1'b1;
      end
      round_nxt = '0;
    end
    if (state_r == ST_SORT) begin
      round_nxt = round_r + CNT_W'(1);
    end
    if (out_acc && last_out) begin
      fill_nxt     = '0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      fill_r     <= '0;
      overflow_r <= 1'b0;
      round_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      overflow_r <= overflow_nxt;
      round_r    <= round_nxt;
    end
  end

endmodule

// File: rtl/core/record_insertion_sorter.sv
// record_insertion_sorter
// in_ch takes one record word per cycle while in_ch.ready is high: text
// words, age and final_record. Up to RECORDS (8) records are held; words
// past that are taken and dropped, and dropped is then set on every result
// of that load. cfg_ch writes sort_by_name (0: age, 1: name, both
// descending, equal keys in arrival order); it is always ready.
// The records sit in a row of cells. Loading shifts the row by one cell per
// word. After the final word the row runs RECORDS rounds of odd-even
// neighbor exchange, one round per cycle, and then offers the first result.
// Results then leave from the head cell, one per cycle while out_ch.ready
// is high; end_of_run marks the last.
// in_ch.ready stays low from the final word until the last result is
// taken. When the receiver stalls, the head result and the whole row hold.
// Reset empties the row, clears the counters and sets sort_by_name to 0.
`include "record_insertion_sorter_macros.svh"

module record_insertion_sorter import ris_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  ris_in_if.sink     in_ch,
  ris_out_if.source  out_ch,
  ris_cfg_if.sink    cfg_ch
);

  logic             sort_by_name_r;
  logic             in_acc, out_acc, last_out;
  logic             in_ready, out_valid, dropped;
  logic [TAG_W-1:0] tag;
  seq_ctl_t         ctl;
  cell_t            new_cell;
  cell_t            cells [RECORDS];
  logic             wins  [RECORDS];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_by_name_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      sort_by_name_r <= cfg_ch.sort_by_name;
    end
  end

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign out_acc     = out_valid && out_ch.ready;

  assign new_cell.valid           = 1'b1;
  assign new_cell.slot.tag        = tag;
  assign new_cell.slot.rec.name   = {in_ch.name_a, in_ch.name_b, in_ch.name_c} & TEXT_MASK;
  assign new_cell.slot.rec.region =
    {in_ch.region_a, in_ch.region_b, in_ch.region_c} & TEXT_MASK;
  assign new_cell.slot.rec.age    = in_ch.age;

  ris_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_final  (in_ch.final_record),
    .out_acc   (out_acc),
    .last_out  (last_out),
    .ctl       (ctl),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .dropped   (dropped),
    .tag       (tag)
  );

  for (genvar i = 0; i < RECORDS; i++) begin : g_cell
    cell_t     left_c, right_c;
    cell_ctl_t cc;
    logic      left_swap, right_swap;

    if (i == 0) begin : g_head
      assign left_c    = new_cell;
      assign left_swap = 1'b0;
    end else begin : g_mid
      assign left_c    = cells[i-1];
      // pair (i-1, i) exchanges in rounds of its parity
      assign left_swap = ctl.sort_en && (ctl.parity == 1'((i - 1) % 2)) && wins[i-1];
    end

    if (i == RECORDS - 1) begin : g_tail
      assign right_c    = '0;
      assign right_swap = 1'b0;
    end else begin : g_body
      assign right_c    = cells[i+1];
      assign right_swap = ctl.sort_en && (ctl.parity == 1'(i % 2)) && wins[i];
    end

    assign cc.take_left  = ctl.shift_up || left_swap;
    assign cc.take_right = ctl.shift_down || right_swap;

    ris_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cc),
      .by_name    (sort_by_name_r),
      .left_i     (left_c),
      .right_i    (right_c),
      .cell_o     (cells[i]),
      .right_wins (wins[i])
    );
  end

  if (RECORDS == 1) begin : g_one
    assign last_out = 1'b1;
  end else begin : g_many
    assign last_out = !cells[1].valid;
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_name_a   = cells[0].slot.rec.name[TEXT_W-1 -: 64];
  assign out_ch.out_name_b   = cells[0].slot.rec.name[TEXT_W-65 -: 64];
  assign out_ch.out_name_c   = cells[0].slot.rec.name[31:0];
  assign out_ch.out_region_a = cells[0].slot.rec.region[TEXT_W-1 -: 64];
  assign out_ch.out_region_b = cells[0].slot.rec.region[TEXT_W-65 -: 64];
  assign out_ch.out_region_c = cells[0].slot.rec.region[31:0];
  assign out_ch.out_age      = cells[0].slot.rec.age;
  assign out_ch.dropped      = dropped;
  assign out_ch.end_of_run   = last_out;

  `RIS_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input open while results pending")
  `RIS_ASSERT_NEXT(a_sort_gap, in_acc && in_ch.final_record, !out_valid, "result before sort")
  `RIS_ASSERT_NOW(a_head_valid, out_valid, cells[0].valid, "result offered from empty head cell")
  `RIS_ASSERT_NEXT(a_reopen, out_acc && last_out, in_ready, "input not reopened after run")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ris_pkg::*;

  typedef struct packed {
    rec_t rec;
    logic dropped;
    logic last;
  } sorted_word_t;

  typedef struct {
    bit         mode;
    rec_t       rec;
    bit         fin;
    bit         typed;
    logic [7:0] x_age;
    bit         x_dropped;
  } plan_row_t;

  logic clk;
  logic rst_n;

  ris_in_if  in_ch();
  ris_out_if out_ch();
  ris_cfg_if cfg_ch();

  record_insertion_sorter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the block: records held for the open load and the sort mode
  rec_t         load_held[$];
  bit           load_overflow;
  bit           by_name;
  sorted_word_t sorted_due[$];
  plan_row_t    plan[$];

  bit calm;
  bit long_hold_done;
  int errors;
  int records_sent;
  int results_taken;
  int loads_done;
  int name_loads;
  int overflow_loads;

  sorted_word_t want;
  sorted_word_t got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic plan_row_t plan_row(bit mode, logic [159:0] name, logic [159:0] region,
                                         logic [7:0] age, bit fin, bit typed,
                                         logic [7:0] x_age, bit x_dropped);
    plan_row_t p;
    p.mode       = mode;
    p.rec.name   = name;
    p.rec.region = region;
    p.rec.age    = age;
    p.fin        = fin;
    p.typed      = typed;
    p.x_age      = x_age;
    p.x_dropped  = x_dropped;
    return p;
  endfunction

  // stores one record; on the final one queues the whole load in sorted order
  function automatic void file_record(rec_t r, bit fin);
    rec_t       work[$];
    rec_t       t;
    logic [7:0] ca;
    logic [7:0] cb;
    bit         swap;
    int         n;
    // bytes past the text length read as zero
    for (int b = TEXT_BYTES; b < FIELD_BYTES; b++) begin
      r.name[TEXT_W-1-8*b -: 8]   = 8'h00;
      r.region[TEXT_W-1-8*b -: 8] = 8'h00;
    end
    if (load_held.size() < RECORDS) begin
      load_held.push_back(r);
    end else begin
      load_overflow = 1'b1;
    end
    if (!fin) return;
    work = load_held;
    n    = work.size();
    // stable: only a strictly smaller key moves down
    for (int i = 1; i < n; i++) begin
      for (int j = i; j >= 1; j--) begin
        swap = 1'b0;
        if (by_name) begin
          for (int k = 0; k < FIELD_BYTES; k++) begin
            ca = work[j-1].name[TEXT_W-1-8*k -: 8];
            cb = work[j].name[TEXT_W-1-8*k -: 8];
            if (ca != cb) begin
              swap = (ca < cb);
              break;
            end
            if (ca == 8'h00) break;
          end
        end else begin
          swap = (work[j-1].age < work[j].age);
        end
        if (swap) begin
          t         = work[j-1];
          work[j-1] = work[j];
          work[j]   = t;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      sorted_due.push_back('{rec: work[i], dropped: load_overflow, last: (i == n - 1)});
    end
    loads_done++;
    if (by_name) name_loads++;
    if (load_overflow) overflow_loads++;
    load_held.delete();
    load_overflow = 1'b0;
  endfunction

  task automatic check_field(input string what, input logic [159:0] exp_v,
                             input logic [159:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic send_record(input rec_t r, input bit fin);
    in_ch.valid        <= 1'b1;
    in_ch.name_a       <= r.name[159:96];
    in_ch.name_b       <= r.name[95:32];
    in_ch.name_c       <= r.name[31:0];
    in_ch.region_a     <= r.region[159:96];
    in_ch.region_b     <= r.region[95:32];
    in_ch.region_c     <= r.region[31:0];
    in_ch.age          <= r.age;
    in_ch.final_record <= fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    file_record(r, fin);
    records_sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // mode changes only once the block has drained its last load
  task automatic set_sort_mode(input bit m);
    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.sort_by_name <= m;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    by_name = m;
  endtask

  // receiver: random stalls, one long hold-off, none near the end
  initial begin
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!calm && !long_hold_done && results_taken >= 30) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (250) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.rec.name   = {out_ch.out_name_a, out_ch.out_name_b, out_ch.out_name_c};
      got.rec.region = {out_ch.out_region_a, out_ch.out_region_b, out_ch.out_region_c};
      got.rec.age    = out_ch.out_age;
      got.dropped    = out_ch.dropped;
      got.last       = out_ch.end_of_run;
      results_taken++;
      if (sorted_due.size() == 0) begin
        $display("%0t: sorted word mismatch, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = sorted_due.pop_front();
        check_field("name", want.rec.name, got.rec.name);
        check_field("region", want.rec.region, got.rec.region);
        check_field("age", want.rec.age, got.rec.age);
        check_field("dropped", want.dropped, got.dropped);
        check_field("end_of_run", want.last, got.last);
      end
    end
  end

  initial begin
    logic [159:0] load_names[$];
    rec_t         r;
    sorted_word_t w;
    int           random_sent;
    int           n;
    int           style;
    int           len;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.name_a        <= '0;
    in_ch.name_b        <= '0;
    in_ch.name_c        <= '0;
    in_ch.region_a      <= '0;
    in_ch.region_b      <= '0;
    in_ch.region_c      <= '0;
    in_ch.age           <= '0;
    in_ch.final_record  <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.sort_by_name <= 1'b0;
    by_name             = 1'b0;
    load_overflow       = 1'b0;

    // single-record loads at the extremes, right after reset
    plan.push_back(plan_row(0, '0, '0, 8'd0, 1, 1, 8'd0, 0));
    plan.push_back(plan_row(0, '1, '1, 8'd255, 1, 1, 8'd255, 0));
    // by age, with a tie that must keep arrival order
    plan.push_back(plan_row(0, {8'h41, 152'h0}, {20{8'h11}}, 8'd7, 0, 0, 0, 0));
    plan.push_back(plan_row(0, {8'h42, 152'h0}, {20{8'h22}}, 8'd255, 0, 0, 0, 0));
    plan.push_back(plan_row(0, {8'h43, 152'h0}, {20{8'h33}}, 8'd7, 0, 0, 0, 0));
    plan.push_back(plan_row(0, {8'h44, 152'h0}, {20{8'h44}}, 8'd0, 1, 0, 0, 0));
    // by name: bytes after a zero ignored, unsigned bytes, last byte decides
    plan.push_back(plan_row(1, {32'h6162_0078, 128'h0}, {20{8'h5a}}, 8'd5, 0, 0, 0, 0));
    plan.push_back(plan_row(1, {8'h01, 152'h0}, {20{8'h5b}}, 8'd9, 0, 0, 0, 0));
    plan.push_back(plan_row(1, {{19{8'h61}}, 8'h61}, {20{8'h5c}}, 8'd1, 0, 0, 0, 0));
    plan.push_back(plan_row(1, {32'h6162_0079, 128'h0}, {20{8'h5d}}, 8'd3, 0, 0, 0, 0));
    plan.push_back(plan_row(1, {8'hff, 152'h0}, {20{8'h5e}}, 8'd2, 0, 0, 0, 0));
    plan.push_back(plan_row(1, {8'h00, 8'h7a, 144'h0}, {20{8'h5f}}, 8'd4, 0, 0, 0, 0));
    plan.push_back(plan_row(1, {{19{8'h61}}, 8'h62}, {20{8'h60}}, 8'd6, 1, 0, 0, 0));
    // overfull load whose final record is itself dropped
    for (int i = 0; i < 10; i++) begin
      plan.push_back(plan_row(0, {20{8'(8'h30 + i)}}, {20{8'(8'ha0 + i)}},
                              8'((i % 4) * 85), (i == 9), 0, 0, 0));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].mode != by_name) begin
        set_sort_mode(plan[i].mode);
      end else if (i != 0) begin
        sender_gap();
      end
      send_record(plan[i].rec, plan[i].fin);
      if (plan[i].typed) begin
        w.rec     = plan[i].rec;
        w.rec.age = plan[i].x_age;
        w.dropped = plan[i].x_dropped;
        w.last    = 1'b1;
        sorted_due[sorted_due.size() - 1] = w;
      end
    end

    random_sent = 0;
    while (random_sent < 195) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) begin
        set_sort_mode(!by_name);
      end else begin
        sender_gap();
      end
      load_names.delete();
      for (int k = 0; k < n; k++) begin
        r.region = {$urandom, $urandom, $urandom, $urandom, $urandom};
        style    = $urandom_range(0, 3);
        if (style == 3 && load_names.size() != 0) begin
          // repeat a name of this load to force ties
          r.name = load_names[$urandom_range(0, load_names.size() - 1)];
        end else if (style == 0 || style == 3) begin
          r.name = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
          // short names from a tiny alphabet, sometimes with junk after the zero
          r.name = '0;
          len    = $urandom_range(0, 6);
          for (int b = 0; b < len; b++) begin
            r.name[159-8*b -: 8] = 8'(8'h61 + $urandom_range(0, 2));
          end
          if ($urandom_range(0, 1) == 1) begin
            for (int b = len + 1; b < 20; b++) begin
              r.name[159-8*b -: 8] = 8'($urandom);
            end
          end
        end
        case ($urandom_range(0, 3))
          0:       r.age = 8'($urandom_range(0, 3));
          1:       r.age = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
          default: r.age = 8'($urandom);
        endcase
        load_names.push_back(r.name);
        if (k != 0) sender_gap();
        send_record(r, (k == n - 1));
        random_sent++;
        if (random_sent >= 170) calm = 1'b1;
      end
    end
    in_ch.valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk);
    repeat (4 * RECORDS) @(posedge clk);

    $display("covered %0d records in %0d loads: %0d sorted by name, %0d overfull",
             records_sent, loads_done, name_loads, overflow_loads);
    $display("checked %0d sorted words under random stalls on both sides", results_taken);
    if (errors == 0 && sorted_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
